>>> rtl/core/rcl_pkg.sv
// shared constants and types for the rgb to cie lab pixel core
`default_nettype none

package rcl_pkg;

    // output format
    localparam int FRACTION_BITS = 8;

    // internal fixed-point formats
    localparam int T_FRAC = 24;                  // normalized xyz, 0..2^24
    localparam int T_W    = T_FRAC + 1;
    localparam int F_FRAC = 20;                  // f(t) values
    localparam int F_W    = F_FRAC + 1;

    typedef logic [7:0]     t_chan;
    typedef logic [T_W-1:0] t_norm;
    typedef logic [F_W-1:0] t_fval;

    // pipeline depth
    localparam int NORM_LAT   = 4;
    localparam int CBRT_STEPS = F_W;
    localparam int LABF_LAT   = CBRT_STEPS + 3;
    localparam int OUT_LAT    = 3;
    localparam int PIPE_LAT   = NORM_LAT + LABF_LAT + OUT_LAT;

    // rgb to xyz matrix, scaled by 1e6, one row per xyz channel
    localparam logic [19:0] RGB_COEF [3][3] = '{
        '{20'd412453, 20'd357580, 20'd180423},
        '{20'd212671, 20'd715160, 20'd72169},
        '{20'd19334,  20'd119193, 20'd950227}
    };

    // d65 white point, scaled by 1e6
    localparam longint unsigned WHITE_X = 950456;
    localparam longint unsigned WHITE_Y = 1000000;
    localparam longint unsigned WHITE_Z = 1088754;

    localparam longint unsigned DEN_X = 255 * WHITE_X;
    localparam longint unsigned DEN_Y = 255 * WHITE_Y;
    localparam longint unsigned DEN_Z = 255 * WHITE_Z;

    // normalize divider: q0 = (num * recip) >> NORM_SHIFT, then fix up by 0..2
    localparam int NUM_W      = 29;
    localparam int NORM_SHIFT = 32;
    localparam int NREM_W     = 32;
    localparam longint unsigned RECIP_X = (64'd1 << (NORM_SHIFT + T_FRAC)) / DEN_X;
    localparam longint unsigned RECIP_Y = (64'd1 << (NORM_SHIFT + T_FRAC)) / DEN_Y;
    localparam longint unsigned RECIP_Z = (64'd1 << (NORM_SHIFT + T_FRAC)) / DEN_Z;

    localparam logic [NUM_W-1:0] NORM_DEN [3] = '{
        NUM_W'(DEN_X), NUM_W'(DEN_Y), NUM_W'(DEN_Z)
    };
    localparam logic [NUM_W-1:0] NORM_RECIP [3] = '{
        NUM_W'(RECIP_X), NUM_W'(RECIP_Y), NUM_W'(RECIP_Z)
    };
    localparam logic [NREM_W-1:0] NORM_HALF [3] = '{
        NREM_W'(DEN_X / 2), NREM_W'(DEN_Y / 2), NREM_W'(DEN_Z / 2)
    };
    localparam logic [NREM_W-1:0] NORM_DEN2 [3] = '{
        NREM_W'(2 * DEN_X), NREM_W'(2 * DEN_Y), NREM_W'(2 * DEN_Z)
    };

    // t > 0.008856 decided exactly
    localparam longint unsigned BRIGHT_MIN = ((64'd8856 << T_FRAC) / 1000000) + 1;

    // dark branch of f: (7787 t + 8000) / 16000 + 16/116
    localparam int DARK_W        = 18;           // dark t always fits
    localparam int DARK_V_W      = 31;
    localparam int DARK_GAIN     = 7787;
    localparam int DARK_RND      = 8000;
    localparam int DIV_POW       = 7;            // 16000 = 128 * 125
    localparam int DIV125_SHIFT  = 31;
    localparam longint unsigned DIV125_RECIP = ((64'd1 << DIV125_SHIFT) + 124) / 125;
    localparam int DARK_Q_W      = 17;
    localparam longint unsigned DARK_OFFSET = ((64'd16 << F_FRAC) + 58) / 116;

    // output scaling
    localparam int SCALE_SH   = F_FRAC - FRACTION_BITS;
    localparam int SCALE_HALF = 1 << (SCALE_SH - 1);
    localparam int L_OFFSET   = 16 << FRACTION_BITS;
    localparam int L_GAIN     = 116;
    localparam int A_GAIN     = 500;
    localparam int B_GAIN     = 200;

    // dark lightness: (9033 t 2^fb + 5 2^24) / (10 2^24)
    localparam int L_DARK_COEF = 9033;
    localparam longint unsigned L_DARK_BIAS = 64'd5 << T_FRAC;
    localparam int L_U_W        = 9 + FRACTION_BITS;
    localparam int DIV10_SHIFT  = 22;
    localparam longint unsigned DIV10_RECIP = ((64'd1 << DIV10_SHIFT) + 9) / 10;

    localparam int LIGHT_SAT = 32767;
    localparam int LIGHT_MAX = ((100 << FRACTION_BITS) < LIGHT_SAT) ?
                               (100 << FRACTION_BITS) : LIGHT_SAT;

endpackage

`default_nettype wire

>>> rtl/core/rcl_norm.sv
// rgb to xyz matrix and white point normalization, four stages
`default_nettype none

module rcl_norm import rcl_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en,
    input  t_chan            i_red,
    input  t_chan            i_green,
    input  t_chan            i_blue,
    output t_norm [2:0]      o_t
);

    localparam int NLO_W = NREM_W - T_FRAC;

    for (genvar ch = 0; ch < 3; ch++) begin : g_ch
        logic [NUM_W-1:0]       r_num, n_num;
        logic [2*NUM_W-1:0]     prod_m;
        logic [T_W-1:0]         r_q0, n_q0, r_q0b;
        logic [NLO_W-1:0]       r_nlo2, r_nlo3;
        logic [NUM_W+T_W-1:0]   prod_d;
        logic [NREM_W-1:0]      r_plo, n_plo, rem;
        logic [T_W-1:0]         r_t, n_t;

        // matrix row
        assign n_num = NUM_W'(RGB_COEF[ch][0]) * NUM_W'(i_red)
                     + NUM_W'(RGB_COEF[ch][1]) * NUM_W'(i_green)
                     + NUM_W'(RGB_COEF[ch][2]) * NUM_W'(i_blue);

        // reciprocal estimate, low by at most two
        assign prod_m = (2*NUM_W)'(r_num) * (2*NUM_W)'(NORM_RECIP[ch]);
        assign n_q0   = prod_m[NORM_SHIFT +: T_W];

        // back-multiply, only low bits matter for the remainder
        assign prod_d = (NUM_W+T_W)'(r_q0) * (NUM_W+T_W)'(NORM_DEN[ch]);
        assign n_plo  = prod_d[NREM_W-1:0];

        assign rem = {r_nlo3, {T_FRAC{1'b0}}} + NORM_HALF[ch] - r_plo;

        always_comb begin
            priority if (rem >= NORM_DEN2[ch]) begin
                n_t = r_q0b + T_W'(2);
            end else if (rem >= NREM_W'(NORM_DEN[ch])) begin
                n_t = r_q0b + T_W'(1);
            end else begin
                n_t = r_q0b;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num  <= n_num;
                r_q0   <= n_q0;
                r_nlo2 <= r_num[NLO_W-1:0];
                r_plo  <= n_plo;
                r_q0b  <= r_q0;
                r_nlo3 <= r_nlo2;
                r_t    <= n_t;
            end
        end

        assign o_t[ch] = r_t;
    end

endmodule

`default_nettype wire

>>> rtl/core/rcl_cbrt.sv
// pipelined integer cube root, one result bit per stage
`default_nettype none

module rcl_cbrt import rcl_pkg::*; (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_norm i_t,
    output t_fval o_root,
    output t_norm o_t
);

    localparam int RAD_W = 3 * CBRT_STEPS;
    localparam int RAD_SH = 2 * F_FRAC - T_FRAC + F_FRAC;
    localparam int SQ_W  = 2 * F_W;
    localparam int REM_W = SQ_W + 6;

    t_fval            r_y   [CBRT_STEPS];
    logic [SQ_W-1:0]  r_sq  [CBRT_STEPS];
    logic [REM_W-1:0] r_rem [CBRT_STEPS];
    t_norm            r_t   [CBRT_STEPS];

    t_fval            n_y   [CBRT_STEPS];
    logic [SQ_W-1:0]  n_sq  [CBRT_STEPS];
    logic [REM_W-1:0] n_rem [CBRT_STEPS];
    t_norm            n_t   [CBRT_STEPS];

    // y is the root so far, sq = y*y, rem = radicand prefix - y^3
    always_comb begin
        t_fval            y_in;
        logic [SQ_W-1:0]  sq_in;
        logic [REM_W-1:0] rem_in;
        logic [RAD_W-1:0] rad;
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] cand;
        for (int k = 0; k < CBRT_STEPS; k++) begin
            if (k == 0) begin
                y_in   = '0;
                sq_in  = '0;
                rem_in = '0;
                n_t[k] = i_t;
            end else begin
                y_in   = r_y[k-1];
                sq_in  = r_sq[k-1];
                rem_in = r_rem[k-1];
                n_t[k] = r_t[k-1];
            end
            rad    = RAD_W'(n_t[k]) << RAD_SH;
            rem_sh = {rem_in[REM_W-4:0], rad[RAD_W-1-3*k -: 3]};
            // (2y+1)^3 - (2y)^3 = 12y^2 + 6y + 1
            cand   = (REM_W'(sq_in) << 3) + (REM_W'(sq_in) << 2)
                   + (REM_W'(y_in) << 2) + (REM_W'(y_in) << 1) + REM_W'(1);
            if (rem_sh >= cand) begin
                n_rem[k] = rem_sh - cand;
                n_y[k]   = {y_in[F_W-2:0], 1'b1};
                n_sq[k]  = (sq_in << 2) + (SQ_W'(y_in) << 2) + SQ_W'(1);
            end else begin
                n_rem[k] = rem_sh;
                n_y[k]   = {y_in[F_W-2:0], 1'b0};
                n_sq[k]  = sq_in << 2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < CBRT_STEPS; k++) begin
                r_y[k]   <= n_y[k];
                r_sq[k]  <= n_sq[k];
                r_rem[k] <= n_rem[k];
                r_t[k]   <= n_t[k];
            end
        end
    end

    assign o_root = r_y[CBRT_STEPS-1];
    assign o_t    = r_t[CBRT_STEPS-1];

endmodule

`default_nettype wire

>>> rtl/core/rcl_lab_f.sv
// lab companding function f(t): cube root or linear dark segment
`default_nettype none

module rcl_lab_f import rcl_pkg::*; (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_norm i_t,
    output t_fval o_f,
    output t_norm o_t,
    output logic  o_bright
);

    localparam int DARK_P_W = (DARK_V_W - DIV_POW) + 25;

    t_fval root;
    t_norm t_c;

    rcl_cbrt u_cbrt (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_t    (i_t),
        .o_root (root),
        .o_t    (t_c)
    );

    t_fval                r_root1, r_root2;
    t_norm                r_t1, r_t2, r_t3;
    logic                 r_br1, r_br2, r_br3;
    logic [DARK_V_W-1:0]  r_v1, n_v1;
    logic [DARK_P_W-1:0]  prod_q;
    logic [DARK_Q_W-1:0]  r_q2;
    t_fval                r_f, n_f;

    assign n_v1   = DARK_V_W'(DARK_V_W'(t_c[DARK_W-1:0]) * DARK_V_W'(DARK_GAIN)
                  + DARK_V_W'(DARK_RND));
    // divide by 125 through its reciprocal
    assign prod_q = DARK_P_W'(r_v1[DARK_V_W-1:DIV_POW]) * DARK_P_W'(DIV125_RECIP);
    assign n_f    = r_br2 ? r_root2 : (F_W'(r_q2) + F_W'(DARK_OFFSET));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_root1 <= root;
            r_t1    <= t_c;
            r_br1   <= (T_W+1)'(t_c) >= (T_W+1)'(BRIGHT_MIN);
            r_v1    <= n_v1;
            r_root2 <= r_root1;
            r_t2    <= r_t1;
            r_br2   <= r_br1;
            r_q2    <= prod_q[DIV125_SHIFT +: DARK_Q_W];
            r_f     <= n_f;
            r_t3    <= r_t2;
            r_br3   <= r_br2;
        end
    end

    assign o_f      = r_f;
    assign o_t      = r_t3;
    assign o_bright = r_br3;

endmodule

`default_nettype wire

>>> rtl/core/rgb_to_cielab_pixel_core.sv
// top level of the rgb to cie lab (d65) pixel converter
`default_nettype none

// converts one 8-bit rgb pixel per clock to cie l*a*b* with a d65 white
// point. l* comes out unsigned, a* and b* as saturated two's complement, all
// with FRACTION_BITS fraction bits; the end-of-frame flag rides along with
// its pixel. the core is a fixed 31-stage pipeline: 4 stages for the matrix
// and white normalization, 21 for the cube root (one root bit per stage),
// 3 for the companding select and 3 for the output scaling. a new word is
// taken every clock unless o_stall is high. the whole pipeline advances on
// one enable: while the output word is valid and i_stall is high,
// everything holds and o_stall is raised.
module rgb_to_cielab_pixel_core import rcl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input word
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic        i_end_of_frame,
    // output word
    output logic        o_valid,
    input  logic        i_stall,
    output logic [14:0] o_lightness,
    output logic [15:0] o_green_red_axis,
    output logic [15:0] o_blue_yellow_axis,
    output logic        o_frame_end
);

    // signed saturation of a rounded magnitude to 16 bits
    function automatic logic [15:0] sat_axis(input logic neg, input logic [31:0] mag);
        logic [15:0] res;
        if (neg) begin
            if (mag > 32'd32768) begin
                res = 16'h8000;
            end else begin
                res = 16'(17'd0 - mag[16:0]);
            end
        end else begin
            if (mag > 32'd32767) begin
                res = 16'h7fff;
            end else begin
                res = mag[15:0];
            end
        end
        return res;
    endfunction

    // global pipeline advance
    logic                pipe_en;
    logic [PIPE_LAT-1:0] r_vld;
    logic [PIPE_LAT-1:0] r_eof;

    assign pipe_en = ~(r_vld[PIPE_LAT-1] & i_stall);
    assign o_stall = ~pipe_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (pipe_en) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_eof <= {r_eof[PIPE_LAT-2:0], i_end_of_frame};
        end
    end

    // normalized x, y, z
    t_norm [2:0] t_xyz;

    rcl_norm u_norm (
        .i_clk   (i_clk),
        .i_en    (pipe_en),
        .i_red   (i_red),
        .i_green (i_green),
        .i_blue  (i_blue),
        .o_t     (t_xyz)
    );

    // f(x), f(y), f(z); y also hands on its t and branch for l*
    t_fval fx, fy, fz;
    t_norm ty;
    logic  bright_y;

    rcl_lab_f u_lab_fx (
        .i_clk    (i_clk),
        .i_en     (pipe_en),
        .i_t      (t_xyz[0]),
        .o_f      (fx),
        .o_t      (),
        .o_bright ()
    );

    rcl_lab_f u_lab_fy (
        .i_clk    (i_clk),
        .i_en     (pipe_en),
        .i_t      (t_xyz[1]),
        .o_f      (fy),
        .o_t      (ty),
        .o_bright (bright_y)
    );

    rcl_lab_f u_lab_fz (
        .i_clk    (i_clk),
        .i_en     (pipe_en),
        .i_t      (t_xyz[2]),
        .o_f      (fz),
        .o_t      (),
        .o_bright ()
    );

    // stage e1: differences times gains, l* products
    logic signed [F_W:0]  d_xy, d_yz;
    logic signed [31:0]   r_ea, r_eb;
    logic [27:0]          r_lb;
    logic [31:0]          r_ld;
    logic                 r_br1, r_br2, r_br3;

    assign d_xy = $signed({1'b0, fx}) - $signed({1'b0, fy});
    assign d_yz = $signed({1'b0, fy}) - $signed({1'b0, fz});

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_ea  <= 32'(d_xy) * 32'(A_GAIN);
            r_eb  <= 32'(d_yz) * 32'(B_GAIN);
            r_lb  <= 28'(fy) * 28'(L_GAIN);
            r_ld  <= 32'(ty[DARK_W-1:0]) * 32'(L_DARK_COEF);
            r_br1 <= bright_y;
        end
    end

    // stage e2: rounding to the output scale, bright l* clamp, dark l* prescale
    logic [31:0]        amag, bmag;
    logic [31:0]        r_am, r_bm;
    logic               r_an, r_bn;
    logic [28:0]        lround;
    logic signed [29:0] lsig;
    logic [14:0]        n_lbr, r_lbr;
    logic [47:0]        lsum;
    logic [L_U_W-1:0]   r_u;

    assign amag   = r_ea[31] ? 32'(-r_ea) : 32'(r_ea);
    assign bmag   = r_eb[31] ? 32'(-r_eb) : 32'(r_eb);
    assign lround = (29'(r_lb) + 29'(SCALE_HALF)) >> SCALE_SH;
    assign lsig   = $signed({1'b0, lround}) - $signed(30'(L_OFFSET));
    assign lsum   = (48'(r_ld) << FRACTION_BITS) + 48'(L_DARK_BIAS);

    always_comb begin
        priority if (lsig < 0) begin
            n_lbr = '0;
        end else if (lsig > 30'(LIGHT_SAT)) begin
            n_lbr = 15'(LIGHT_SAT);
        end else begin
            n_lbr = lsig[14:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_am  <= (amag + 32'(SCALE_HALF)) >> SCALE_SH;
            r_bm  <= (bmag + 32'(SCALE_HALF)) >> SCALE_SH;
            r_an  <= r_ea[31];
            r_bn  <= r_eb[31];
            r_lbr <= n_lbr;
            r_u   <= lsum[T_FRAC +: L_U_W];
            r_br2 <= r_br1;
        end
    end

    // stage e3: dark l* divide by 10, branch select, axis saturation
    logic [47:0] lprod;
    logic [15:0] ldq;
    logic [14:0] n_light;
    logic [14:0] r_light;
    logic [15:0] r_a, r_b;

    assign lprod = 48'(r_u) * 48'(DIV10_RECIP);
    assign ldq   = lprod[DIV10_SHIFT +: 16];

    always_comb begin
        priority if (r_br2) begin
            n_light = r_lbr;
        end else if (ldq > 16'(LIGHT_SAT)) begin
            n_light = 15'(LIGHT_SAT);
        end else begin
            n_light = ldq[14:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_light <= n_light;
            r_a     <= sat_axis(r_an, r_am);
            r_b     <= sat_axis(r_bn, r_bm);
            r_br3   <= r_br2;
        end
    end

    assign o_valid            = r_vld[PIPE_LAT-1];
    assign o_frame_end        = r_eof[PIPE_LAT-1];
    assign o_lightness        = r_light;
    assign o_green_red_axis   = r_a;
    assign o_blue_yellow_axis = r_b;

    // the pipeline only holds back input while a finished word waits
    a_stall_only_on_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no output word waiting");

    a_word_reaches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pipe_en && r_vld[PIPE_LAT-2]) |=> o_valid)
        else $error("word lost in last pipeline stage");

    a_no_phantom_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pipe_en && !r_vld[PIPE_LAT-2]) |=> !o_valid)
        else $error("output word appeared without a source");

    a_lightness_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_br3) |-> (o_lightness <= 15'(LIGHT_MAX)))
        else $error("lightness above white");

endmodule

`default_nettype wire

>>> tb/sv/tb_rgb_to_cielab_pixel_core.sv
// testbench for the rgb to cie lab pixel core: random and corner pixels checked against a predictor
`default_nettype none

module tb_rgb_to_cielab_pixel_core;
    import rcl_pkg::*;

    typedef struct packed {
        logic [14:0] lightness;
        logic [15:0] green_red_axis;
        logic [15:0] blue_yellow_axis;
        logic        frame_end;
    } t_lab_word;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_red;
    logic [7:0]  i_green;
    logic [7:0]  i_blue;
    logic        i_end_of_frame;
    logic        o_valid;
    logic        i_stall;
    logic [14:0] o_lightness;
    logic [15:0] o_green_red_axis;
    logic [15:0] o_blue_yellow_axis;
    logic        o_frame_end;

    t_lab_word   lab_queue[$];
    int          error_count;
    longint      cycle_count;
    int          hold_off_cycles;   // long receiver stall requested by a test
    int          sink_gap_max;      // upper bound of random receiver stalls

    localparam longint CYCLE_LIMIT = 200000;

    rgb_to_cielab_pixel_core uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_red              (i_red),
        .i_green            (i_green),
        .i_blue             (i_blue),
        .i_end_of_frame     (i_end_of_frame),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_lightness        (o_lightness),
        .o_green_red_axis   (o_green_red_axis),
        .o_blue_yellow_axis (o_blue_yellow_axis),
        .o_frame_end        (o_frame_end)
    );

    // 10 unit clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // normalized channel, 24 fraction bits, rounded half up
    function automatic longint unsigned norm_xyz(longint unsigned r, longint unsigned g,
            longint unsigned b, longint unsigned cr, longint unsigned cg,
            longint unsigned cb, longint unsigned white);
        longint unsigned num;
        longint unsigned den;
        num = cr * r + cg * g + cb * b;
        den = 255 * white;
        return ((num << T_FRAC) + den / 2) / den;
    endfunction

    // above the linear segment, decided exactly
    function automatic bit above_knee(longint unsigned t);
        return t * 1000000 > (64'd8856 << T_FRAC);
    endfunction

    // integer cube root, bit by bit
    function automatic longint unsigned cube_root(longint unsigned n);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int k = 20; k >= 0; k--) begin
            trial = root | (64'd1 << k);
            if (trial * trial * trial <= n)
                root = trial;
        end
        return root;
    endfunction

    // companding function, 20 fraction bits
    function automatic longint compand(longint unsigned t);
        if (above_knee(t))
            return longint'(cube_root(t << (2 * F_FRAC - T_FRAC + F_FRAC)));
        return longint'((7787 * t + 8000) / 16000) + longint'(((64'd16 << F_FRAC) + 58) / 116);
    endfunction

    // rescale a difference to the output format, half away from zero, saturated
    function automatic logic [15:0] scale_axis(longint v);
        longint unsigned mag;
        longint q;
        mag = (v < 0) ? longint'(-v) : longint'(v);
        mag = (mag + (64'd1 << (F_FRAC - FRACTION_BITS - 1))) >> (F_FRAC - FRACTION_BITS);
        if (mag > 40000)
            mag = 40000;
        q = (v < 0) ? -longint'(mag) : longint'(mag);
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return q[15:0];
    endfunction

    function automatic t_lab_word convert_pixel(logic [7:0] r, logic [7:0] g,
            logic [7:0] b, logic eof);
        t_lab_word w;
        longint unsigned tx, ty, tz, den;
        longint fx, fy, fz, light;
        tx = norm_xyz(r, g, b, 412453, 357580, 180423, 950456);
        ty = norm_xyz(r, g, b, 212671, 715160, 72169, 1000000);
        tz = norm_xyz(r, g, b, 19334, 119193, 950227, 1088754);
        fx = compand(tx);
        fy = compand(ty);
        fz = compand(tz);
        if (above_knee(ty)) begin
            light = longint'((unsigned'(116 * fy)
                    + (64'd1 << (F_FRAC - FRACTION_BITS - 1))) >> (F_FRAC - FRACTION_BITS))
                    - (longint'(16) << FRACTION_BITS);
        end else begin
            den = 64'd10 << T_FRAC;
            light = longint'((((9033 * ty) << FRACTION_BITS) + den / 2) / den);
        end
        if (light < 0)
            light = 0;
        if (light > 32767)
            light = 32767;
        w.lightness        = light[14:0];
        w.green_red_axis   = scale_axis(500 * (fx - fy));
        w.blue_yellow_axis = scale_axis(200 * (fy - fz));
        w.frame_end        = eof;
        return w;
    endfunction

    // ---------------------------------------------------------------
    // sender
    // ---------------------------------------------------------------

    // offer one pixel after a random gap, return once it is taken
    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic eof,
            int gap_max);
        int gap;
        gap = $urandom_range(gap_max, 0);
        // valid stays high only when this word follows back to back
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_red          <= r;
        i_green        <= g;
        i_blue         <= b;
        i_end_of_frame <= eof;
        // predict at acceptance so the queue order follows the handshake
        do @(posedge i_clk); while (o_stall);
        lab_queue.push_back(convert_pixel(r, g, b, eof));
    endtask

    // drop valid after the last word of a sequence
    task automatic end_sequence();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_random(int n, int gap_max);
        for (int k = 0; k < n; k++)
            send_pixel($urandom_range(255, 0), $urandom_range(255, 0),
                       $urandom_range(255, 0), $urandom_range(1, 0), gap_max);
        end_sequence();
    endtask

    // ---------------------------------------------------------------
    // receiver: random stalls, plus a long hold-off when requested
    // ---------------------------------------------------------------
    initial begin
        int gap;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_cycles > 0) begin
                i_stall <= 1'b1;
                hold_off_cycles--;
            end else begin
                gap = (sink_gap_max == 0) ? 0 : $urandom_range(sink_gap_max, 0);
                if (gap == 0) begin
                    i_stall <= 1'b0;
                end else begin
                    i_stall <= 1'b1;
                    repeat (gap) @(posedge i_clk);
                    i_stall <= 1'b0;
                end
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_lab_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (lab_queue.size() == 0) begin
                $error("unexpected word: L=%0d a=%0d b=%0d", o_lightness,
                       $signed(o_green_red_axis), $signed(o_blue_yellow_axis));
                error_count++;
            end else begin
                want = lab_queue.pop_front();
                if (o_lightness !== want.lightness) begin
                    $error("lightness: expected %0d got %0d", want.lightness, o_lightness);
                    error_count++;
                end
                if (o_green_red_axis !== want.green_red_axis) begin
                    $error("green_red_axis: expected %0d got %0d",
                           $signed(want.green_red_axis), $signed(o_green_red_axis));
                    error_count++;
                end
                if (o_blue_yellow_axis !== want.blue_yellow_axis) begin
                    $error("blue_yellow_axis: expected %0d got %0d",
                           $signed(want.blue_yellow_axis), $signed(o_blue_yellow_axis));
                    error_count++;
                end
                if (o_frame_end !== want.frame_end) begin
                    $error("frame_end: expected %0b got %0b", want.frame_end, o_frame_end);
                    error_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // black, white, primaries, near the knee of f, single bits
    task automatic test_corners();
        send_pixel(8'd0,   8'd0,   8'd0,   1'b0, 2);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b1, 2);
        send_pixel(8'd255, 8'd0,   8'd0,   1'b0, 2);
        send_pixel(8'd0,   8'd255, 8'd0,   1'b0, 2);
        send_pixel(8'd0,   8'd0,   8'd255, 1'b1, 2);
        send_pixel(8'd255, 8'd255, 8'd0,   1'b0, 2);
        send_pixel(8'd255, 8'd0,   8'd255, 1'b0, 2);
        send_pixel(8'd0,   8'd255, 8'd255, 1'b0, 2);
        send_pixel(8'd1,   8'd1,   8'd1,   1'b0, 2);
        send_pixel(8'd2,   8'd2,   8'd2,   1'b0, 2);
        send_pixel(8'd3,   8'd3,   8'd3,   1'b0, 2);
        send_pixel(8'd4,   8'd4,   8'd4,   1'b1, 2);
        send_pixel(8'd0,   8'd0,   8'd1,   1'b0, 2);
        send_pixel(8'd1,   8'd0,   8'd0,   1'b0, 2);
        send_pixel(8'd0,   8'd9,   8'd0,   1'b0, 2);
        send_pixel(8'd128, 8'd64,  8'd32,  1'b0, 2);
        send_pixel(8'd170, 8'd85,  8'd170, 1'b1, 2);
        send_pixel(8'd254, 8'd1,   8'd254, 1'b0, 2);
        // half-intensity blue, alone and with full red
        send_pixel(8'd0,   8'd0,   8'd128, 1'b0, 2);
        send_pixel(8'd255, 8'd0,   8'd128, 1'b0, 2);
        end_sequence();
    endtask

    // random pixels with random gaps on both sides
    task automatic test_random_traffic();
        sink_gap_max = 8;
        send_random(180, 8);
    endtask

    // full rate, receiver never stalls
    task automatic test_full_rate();
        sink_gap_max = 0;
        send_random(100, 0);
    endtask

    // long receiver hold-off while the sender keeps offering: pipe fills, input stalls
    task automatic test_backpressure();
        sink_gap_max = 0;
        hold_off_cycles = 80;
        send_random(60, 0);
        sink_gap_max = 3;
        send_random(40, 1);
    endtask

    initial begin
        error_count     = 0;
        hold_off_cycles = 0;
        sink_gap_max    = 3;
        i_rst_n         <= 1'b0;
        i_valid         <= 1'b0;
        i_red           <= '0;
        i_green         <= '0;
        i_blue          <= '0;
        i_end_of_frame  <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_corners();
        test_random_traffic();
        test_full_rate();
        test_backpressure();

        // drain, then let the pipeline run dry
        while (lab_queue.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 20) @(posedge i_clk);

        if (error_count == 0 && lab_queue.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
rtl/core/rcl_pkg.sv
rtl/core/rcl_norm.sv
rtl/core/rcl_cbrt.sv
rtl/core/rcl_lab_f.sv
rtl/core/rgb_to_cielab_pixel_core.sv
tb/sv/tb_rgb_to_cielab_pixel_core.sv
